/* sv/ethernet_rx_frame_filter_defines.svh */
// Assertion macros used by the checker file.
`ifndef ETHERNET_RX_FRAME_FILTER_DEFINES_SVH
`define ETHERNET_RX_FRAME_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ERFF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ethernet_rx_frame_filter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ERFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ethernet_rx_frame_filter: assertion failed");

`endif

/* sv/erff_pkg.sv */
package erff_pkg;

	localparam int CNT_W = 11;

	localparam logic [CNT_W-1:0] MAX_FRAME_BYTES = CNT_W'(1536);
	localparam logic [CNT_W-1:0] COUNT_LIMIT     = MAX_FRAME_BYTES + CNT_W'(1);
	localparam logic [CNT_W-1:0] HDR_BYTES       = CNT_W'(14);
	localparam logic [CNT_W-1:0] ADDR_BYTES      = CNT_W'(6);
	localparam logic [CNT_W-1:0] TYPE_POS_HI     = CNT_W'(12);
	localparam logic [CNT_W-1:0] TYPE_POS_LO     = CNT_W'(13);

	localparam logic [7:0]  BCAST_BYTE = 8'hFF;
	localparam logic [15:0] TYPE_IPV4  = 16'h0800;
	localparam logic [15:0] TYPE_ARP   = 16'h0806;

	localparam logic [2:0] VERDICT_NOT_LOCAL = 3'd0;
	localparam logic [2:0] VERDICT_OVERRUN   = 3'd1;
	localparam logic [2:0] VERDICT_IPV4      = 3'd2;
	localparam logic [2:0] VERDICT_ARP       = 3'd3;
	localparam logic [2:0] VERDICT_OTHER     = 3'd4;
	localparam logic [2:0] VERDICT_RUNT      = 3'd5;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             ucast;
		logic             bcast;
		logic [15:0]      ftype;
	} frame_sum_t;

	typedef struct packed {
		logic [2:0]       verdict;
		logic [15:0]      frame_type;
		logic [CNT_W-1:0] payload_length;
		logic             is_broadcast;
	} result_t;

endpackage

/* sv/erff_parse.sv */
module erff_parse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    unicast_address_we,
	input  logic [47:0]             unicast_address,
	input  logic                    in_acc,
	input  logic [7:0]              rx_byte,
	input  logic                    last_byte,
	output erff_pkg::frame_sum_t    sum_nxt
);

	logic [47:0]                   ucast_addr_q;
	logic [erff_pkg::CNT_W-1:0]    count_q;
	logic                          ucast_q;
	logic                          bcast_q;
	logic [15:0]                   ftype_q;
	logic [7:0]                    want_byte;

	always_comb begin
		unique case (count_q[2:0])
			3'd0: want_byte = ucast_addr_q[47:40];
			3'd1: want_byte = ucast_addr_q[39:32];
			3'd2: want_byte = ucast_addr_q[31:24];
			3'd3: want_byte = ucast_addr_q[23:16];
			3'd4: want_byte = ucast_addr_q[15:8];
			3'd5: want_byte = ucast_addr_q[7:0];
			default: want_byte = 8'h00;
		endcase
	end

	always_comb begin
		sum_nxt.count = count_q;
		sum_nxt.ucast = ucast_q;
		sum_nxt.bcast = bcast_q;
		sum_nxt.ftype = ftype_q;
		if (count_q < erff_pkg::ADDR_BYTES) begin
			if (rx_byte != want_byte) begin
				sum_nxt.ucast = 1'b0;
			end
			if (rx_byte != erff_pkg::BCAST_BYTE) begin
				sum_nxt.bcast = 1'b0;
			end
		end else if (count_q == erff_pkg::TYPE_POS_HI) begin
			sum_nxt.ftype[15:8] = rx_byte;
		end else if (count_q == erff_pkg::TYPE_POS_LO) begin
			sum_nxt.ftype[7:0] = rx_byte;
		end
		if (count_q < erff_pkg::COUNT_LIMIT) begin
			sum_nxt.count = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ucast_addr_q <= '0;
			count_q      <= '0;
			ucast_q      <= 1'b1;
			bcast_q      <= 1'b1;
			ftype_q      <= '0;
		end else begin
			if (unicast_address_we) begin
				ucast_addr_q <= unicast_address;
			end
			if (in_acc) begin
				if (last_byte) begin
					count_q <= '0;
					ucast_q <= 1'b1;
					bcast_q <= 1'b1;
					ftype_q <= '0;
				end else begin
					count_q <= sum_nxt.count;
					ucast_q <= sum_nxt.ucast;
					bcast_q <= sum_nxt.bcast;
					ftype_q <= sum_nxt.ftype;
				end
			end
		end
	end

endmodule

/* sv/erff_classify.sv */
module erff_classify (
	input  erff_pkg::frame_sum_t sum,
	output erff_pkg::result_t    res
);

	always_comb begin
		res.verdict        = erff_pkg::VERDICT_OTHER;
		res.frame_type     = sum.ftype;
		res.payload_length = sum.count - erff_pkg::HDR_BYTES;
		res.is_broadcast   = sum.bcast;
		if (sum.count < erff_pkg::HDR_BYTES) begin
			res.verdict        = erff_pkg::VERDICT_RUNT;
			res.frame_type     = '0;
			res.payload_length = '0;
			res.is_broadcast   = 1'b0;
		end else if (!sum.ucast && !sum.bcast) begin
			res.verdict = erff_pkg::VERDICT_NOT_LOCAL;
		end else if (sum.count > erff_pkg::MAX_FRAME_BYTES) begin
			res.verdict = erff_pkg::VERDICT_OVERRUN;
		end else if (sum.ftype == erff_pkg::TYPE_IPV4) begin
			res.verdict = erff_pkg::VERDICT_IPV4;
		end else if (sum.ftype == erff_pkg::TYPE_ARP) begin
			res.verdict = erff_pkg::VERDICT_ARP;
		end
	end

endmodule

/* sv/erff_out.sv */
module erff_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  erff_pkg::result_t res,
	output logic              skid_full,
	output logic              out_valid,
	input  logic              out_stall,
	output erff_pkg::result_t out_res
);

	logic              out_valid_q;
	logic              skid_valid_q;
	erff_pkg::result_t out_q;
	erff_pkg::result_t skid_q;
	logic              out_take;

	assign out_take  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign skid_full = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (res_valid) begin
				if (out_valid_q && !out_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

endmodule

/* sv/ethernet_rx_frame_filter.sv */
// Receive destination filter and classifier for Ethernet frames, one byte per transfer with
// last_byte marking the final byte. While in_stall is low, a frame streams through at one
// byte per clock; the frame state is updated as each byte is taken, and the verdict is
// registered by the edge that takes the last byte; if the output register is free, it is
// offered from the next cycle. A two-entry result stage lets bytes keep flowing while a
// verdict waits to be taken, and in_stall rises only when both entries are occupied.
// unicast_address is sampled at every rising edge at which unicast_address_we is high.
module ethernet_rx_frame_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unicast_address_we,
	input  logic [47:0] unicast_address,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic [15:0] frame_type,
	output logic [10:0] payload_length,
	output logic        is_broadcast
);

	logic                 in_acc;
	logic                 skid_full;
	erff_pkg::frame_sum_t sum_nxt;
	erff_pkg::result_t    res;
	erff_pkg::result_t    out_res;

	assign in_stall = skid_full;
	assign in_acc   = in_valid && !skid_full;

	erff_parse u_parse (
		.clk                (clk),
		.arst_n             (arst_n),
		.unicast_address_we (unicast_address_we),
		.unicast_address    (unicast_address),
		.in_acc             (in_acc),
		.rx_byte            (rx_byte),
		.last_byte          (last_byte),
		.sum_nxt            (sum_nxt)
	);

	erff_classify u_classify (
		.sum (sum_nxt),
		.res (res)
	);

	erff_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (in_acc && last_byte),
		.res       (res),
		.skid_full (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign verdict        = out_res.verdict;
	assign frame_type     = out_res.frame_type;
	assign payload_length = out_res.payload_length;
	assign is_broadcast   = out_res.is_broadcast;

endmodule

/* sv/erff_checker.sv */
`include "ethernet_rx_frame_filter_defines.svh"

module erff_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        unicast_address_we,
	input logic [47:0] unicast_address,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  rx_byte,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  verdict,
	input logic [15:0] frame_type,
	input logic [10:0] payload_length,
	input logic        is_broadcast
);

	logic        in_take;
	logic        out_held;
	logic [30:0] out_word;
	logic        out_runt;
	logic        out_not_local;
	logic        out_overrun;
	logic        runt_fields_zero;
	logic        len_at_limit;

	assign in_take          = in_valid && !in_stall;
	assign out_held         = out_valid && out_stall;
	assign out_word         = {verdict, frame_type, payload_length, is_broadcast};
	assign out_runt         = out_valid && verdict == erff_pkg::VERDICT_RUNT;
	assign out_not_local    = out_valid && verdict == erff_pkg::VERDICT_NOT_LOCAL;
	assign out_overrun      = out_valid && verdict == erff_pkg::VERDICT_OVERRUN;
	assign runt_fields_zero = frame_type == 16'd0 && payload_length == 11'd0 && !is_broadcast;
	assign len_at_limit     = payload_length == erff_pkg::COUNT_LIMIT - erff_pkg::HDR_BYTES;

	`ERFF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(out_word))
	`ERFF_ASSERT_SAME(a_rise_from_last, clk, arst_n, $rose(out_valid), $past(in_take && last_byte))
	`ERFF_ASSERT_SAME(a_runt_zero, clk, arst_n, out_runt, runt_fields_zero)
	`ERFF_ASSERT_SAME(a_not_local_no_bcast, clk, arst_n, out_not_local, !is_broadcast)
	`ERFF_ASSERT_SAME(a_overrun_len, clk, arst_n, out_overrun, len_at_limit)

endmodule

bind ethernet_rx_frame_filter erff_checker u_erff_checker (.*);

/* tb/sv/tb_top.sv */
module tb_top;

	typedef enum {DST_STATION, DST_BCAST, DST_FOREIGN, DST_NEAR} dst_kind_t;

	typedef struct {
		logic              new_addr;
		logic [47:0]       addr;
		dst_kind_t         dst;
		logic [15:0]       ftype;
		int                len;
		logic              typed;
		erff_pkg::result_t want;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        unicast_address_we = 1'b0;
	logic [47:0] unicast_address = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  verdict;
	logic [15:0] frame_type;
	logic [10:0] payload_length;
	logic        is_broadcast;

	// Classifier state kept alongside the block.
	logic [47:0] station_addr = '0;
	int          seen_count = 0;
	logic        dst_is_station = 1'b1;
	logic        dst_is_bcast = 1'b1;
	logic [15:0] seen_type = '0;

	erff_pkg::result_t pending_verdicts[$];
	logic [7:0]        frame_bytes[$];
	int                mismatch_count = 0;
	int                bytes_sent = 0;
	bit                tx_gaps_on = 1'b1;
	bit                rx_gaps_on = 1'b1;
	bit                long_hold_req = 1'b0;

	frame_row_t directed_frames [15] = '{
		'{1'b0, 48'h0, DST_STATION, 16'h0800, 14, 1'b1,
			'{erff_pkg::VERDICT_IPV4, 16'h0800, 11'd0, 1'b0}},
		'{1'b0, 48'h0, DST_BCAST, 16'h0800, 1, 1'b1,
			'{erff_pkg::VERDICT_RUNT, 16'h0, 11'd0, 1'b0}},
		'{1'b0, 48'h0, DST_STATION, 16'h0806, 13, 1'b1,
			'{erff_pkg::VERDICT_RUNT, 16'h0, 11'd0, 1'b0}},
		'{1'b0, 48'h0, DST_BCAST, 16'h0806, 60, 1'b0, '0},
		'{1'b0, 48'h0, DST_FOREIGN, 16'h0800, 20, 1'b1,
			'{erff_pkg::VERDICT_NOT_LOCAL, 16'h0800, 11'd6, 1'b0}},
		'{1'b0, 48'h0, DST_STATION, 16'hFFFF, 15, 1'b1,
			'{erff_pkg::VERDICT_OTHER, 16'hFFFF, 11'd1, 1'b0}},
		'{1'b0, 48'h0, DST_STATION, 16'h0000, 14, 1'b0, '0},
		'{1'b1, 48'hFFFF_FFFF_FFFF, DST_STATION, 16'h0806, 30, 1'b1,
			'{erff_pkg::VERDICT_ARP, 16'h0806, 11'd16, 1'b1}},
		'{1'b1, 48'h0123_4567_89AB, DST_STATION, 16'h0800, 1536, 1'b0, '0},
		'{1'b0, 48'h0, DST_BCAST, 16'h0800, 1537, 1'b1,
			'{erff_pkg::VERDICT_OVERRUN, 16'h0800, 11'd1523, 1'b1}},
		'{1'b0, 48'h0, DST_STATION, 16'h0806, 1600, 1'b0, '0},
		'{1'b0, 48'h0, DST_FOREIGN, 16'h0800, 1600, 1'b0, '0},
		'{1'b0, 48'h0, DST_BCAST, 16'h1234, 13, 1'b1,
			'{erff_pkg::VERDICT_RUNT, 16'h0, 11'd0, 1'b0}},
		'{1'b0, 48'h0, DST_NEAR, 16'h0800, 14, 1'b0, '0},
		'{1'b1, 48'hFEDC_BA98_7654, DST_STATION, 16'h0806, 14, 1'b0, '0}
	};

	ethernet_rx_frame_filter u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.unicast_address_we (unicast_address_we),
		.unicast_address    (unicast_address),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.rx_byte            (rx_byte),
		.last_byte          (last_byte),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.verdict            (verdict),
		.frame_type         (frame_type),
		.payload_length     (payload_length),
		.is_broadcast       (is_broadcast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit classify_byte(input logic [7:0] b, input logic l,
			output erff_pkg::result_t r);
		int pos;
		pos = seen_count;
		r = '0;
		if (pos < int'(erff_pkg::ADDR_BYTES)) begin
			if (b != station_addr[47 - 8*pos -: 8])
				dst_is_station = 1'b0;
			if (b != erff_pkg::BCAST_BYTE)
				dst_is_bcast = 1'b0;
		end else if (pos == int'(erff_pkg::TYPE_POS_HI)) begin
			seen_type[15:8] = b;
		end else if (pos == int'(erff_pkg::TYPE_POS_LO)) begin
			seen_type[7:0] = b;
		end
		if (seen_count < int'(erff_pkg::COUNT_LIMIT))
			seen_count++;
		if (!l)
			return 1'b0;
		if (seen_count < int'(erff_pkg::HDR_BYTES)) begin
			r.verdict = erff_pkg::VERDICT_RUNT;
		end else begin
			r.frame_type = seen_type;
			r.payload_length = 11'(seen_count - int'(erff_pkg::HDR_BYTES));
			r.is_broadcast = dst_is_bcast;
			if (!dst_is_station && !dst_is_bcast)
				r.verdict = erff_pkg::VERDICT_NOT_LOCAL;
			else if (seen_count > int'(erff_pkg::MAX_FRAME_BYTES))
				r.verdict = erff_pkg::VERDICT_OVERRUN;
			else if (seen_type == erff_pkg::TYPE_IPV4)
				r.verdict = erff_pkg::VERDICT_IPV4;
			else if (seen_type == erff_pkg::TYPE_ARP)
				r.verdict = erff_pkg::VERDICT_ARP;
			else
				r.verdict = erff_pkg::VERDICT_OTHER;
		end
		seen_count = 0;
		dst_is_station = 1'b1;
		dst_is_bcast = 1'b1;
		seen_type = '0;
		return 1'b1;
	endfunction

	function automatic void build_frame(input dst_kind_t kind, input logic [15:0] ftype,
			input int len);
		logic [47:0] dst;
		int i;
		unique case (kind)
			DST_STATION: dst = station_addr;
			DST_BCAST:   dst = '1;
			DST_NEAR:    dst = station_addr ^ (48'd1 << $urandom_range(0, 47));
			default: begin
				dst = {16'($urandom), $urandom};
				if (dst == station_addr || dst == '1)
					dst[0] = ~dst[0];
			end
		endcase
		frame_bytes.delete();
		for (i = 0; i < len; i++) begin
			if (i < int'(erff_pkg::ADDR_BYTES))
				frame_bytes.push_back(dst[47 - 8*i -: 8]);
			else if (i == int'(erff_pkg::TYPE_POS_HI))
				frame_bytes.push_back(ftype[15:8]);
			else if (i == int'(erff_pkg::TYPE_POS_LO))
				frame_bytes.push_back(ftype[7:0]);
			else
				frame_bytes.push_back(8'($urandom));
		end
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// A byte is in when a transfer completes; the sender may then leave a gap.
	task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
			input erff_pkg::result_t want);
		erff_pkg::result_t r;
		in_valid <= 1'b1;
		rx_byte <= b;
		last_byte <= l;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		if (classify_byte(b, l, r))
			pending_verdicts.push_back(typed ? want : r);
		if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic typed, input erff_pkg::result_t want);
		int i;
		for (i = 0; i < frame_bytes.size(); i++)
			push_byte(frame_bytes[i], i == frame_bytes.size() - 1, typed, want);
	endtask

	task automatic drain_verdicts();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_station_address(input logic [47:0] addr);
		drain_verdicts();
		unicast_address_we <= 1'b1;
		unicast_address <= addr;
		@(posedge clk);
		unicast_address_we <= 1'b0;
		station_addr = addr;
	endtask

	task automatic random_frame();
		dst_kind_t kind;
		logic [15:0] ftype;
		int len;
		int pick;
		pick = $urandom_range(0, 9);
		kind = pick < 4 ? DST_STATION : pick < 7 ? DST_BCAST : pick < 9 ? DST_FOREIGN : DST_NEAR;
		pick = $urandom_range(0, 9);
		ftype = pick < 3 ? erff_pkg::TYPE_IPV4 : pick < 5 ? erff_pkg::TYPE_ARP : 16'($urandom);
		pick = $urandom_range(0, 9);
		len = pick < 2 ? $urandom_range(1, 13) :
			pick < 9 ? $urandom_range(14, 40) : $urandom_range(41, 200);
		build_frame(kind, ftype, len);
		send_frame(1'b0, '0);
	endtask

	always @(posedge clk) begin
		erff_pkg::result_t exp_v;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected transfer, verdict", verdict, 0);
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (verdict !== exp_v.verdict)
					report_mismatch("verdict", verdict, exp_v.verdict);
				if (frame_type !== exp_v.frame_type)
					report_mismatch("frame_type", frame_type, exp_v.frame_type);
				if (payload_length !== exp_v.payload_length)
					report_mismatch("payload_length", payload_length, exp_v.payload_length);
				if (is_broadcast !== exp_v.is_broadcast)
					report_mismatch("is_broadcast", is_broadcast, exp_v.is_broadcast);
			end
		end
	end

	// The long hold is timed here so that the sender keeps offering bytes meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (90) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int i;
		int frames_at_addr;
		int pick;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 15; i++) begin
			if (directed_frames[i].new_addr)
				set_station_address(directed_frames[i].addr);
			build_frame(directed_frames[i].dst, directed_frames[i].ftype, directed_frames[i].len);
			send_frame(directed_frames[i].typed, directed_frames[i].want);
		end

		drain_verdicts();
		tx_gaps_on = 1'b0;
		long_hold_req = 1'b1;
		for (i = 0; i < 24; i++) begin
			build_frame(DST_STATION, erff_pkg::TYPE_IPV4, 1);
			send_frame(1'b0, '0);
		end
		drain_verdicts();

		bytes_sent = 0;
		frames_at_addr = 0;
		while (bytes_sent < 950) begin
			tx_gaps_on = !(bytes_sent >= 800 || (bytes_sent >= 500 && bytes_sent < 650));
			rx_gaps_on = tx_gaps_on;
			if (frames_at_addr == 8) begin
				pick = $urandom_range(0, 5);
				set_station_address(pick == 0 ? 48'h0 : pick == 1 ? '1 :
					{16'($urandom), $urandom});
				frames_at_addr = 0;
			end
			random_frame();
			frames_at_addr++;
		end

		drain_verdicts();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
